// ===== rtl/bcsm_pkg.sv =====
// Shared types and constants of the block cache slot manager.
// Used by the interfaces, the slot cell, the top level and the checker.
package bcsm_pkg;

  localparam int unsigned DefSlotCount = 32;
  localparam int unsigned DefCountBits = 8;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned BLOCK_W  = 32;
  localparam int unsigned HANDLE_W = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DOP_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_MARK    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_SYNC    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_NO_FREE   = 3'd1,
    STS_UNDERFLOW = 3'd2,
    STS_IGNORED   = 3'd3,
    STS_SATURATED = 3'd4
  } status_e;

  typedef enum logic [DOP_W-1:0] {
    DOP_NONE  = 2'd0,
    DOP_WRITE = 2'd1,
    DOP_READ  = 2'd2
  } disk_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH
  } state_e;

  typedef enum logic [2:0] {
    CO_NONE,
    CO_INC,
    CO_DEC,
    CO_DIRTY,
    CO_CLEAN,
    CO_FILL
  } cell_op_e;

  // Update broadcast to the selected cell.
  typedef struct packed {
    cell_op_e           op;
    logic [BLOCK_W-1:0] tag;
  } cell_cmd_t;

  // Scan results rippled from cell to cell, lowest slot first.
  typedef struct packed {
    logic               hit_found;
    logic               hit_max;
    logic               free_found;
    logic               free_wb;
    logic [BLOCK_W-1:0] free_tag;
    logic               dirty_found;
    logic               dirty_more;
    logic [BLOCK_W-1:0] dirty_tag;
  } link_t;

  // Per-cell status seen by the controller.
  typedef struct packed {
    logic valid;
    logic cnt_zero;
    logic hit_first;
    logic free_first;
    logic dirty_first;
  } cell_flags_t;

endpackage

// ===== rtl/bcsm_in_if.sv =====
// Input channel of the block cache slot manager: command, block, handle.
// Depends on bcsm_pkg for field widths.
interface bcsm_in_if;
  import bcsm_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [BLOCK_W-1:0]  block_number;
  logic [HANDLE_W-1:0] slot_index;

  modport source (output valid, output command, output block_number, output slot_index,
                  input ready);
  modport sink   (input valid, input command, input block_number, input slot_index,
                  output ready);
endinterface

// ===== rtl/bcsm_out_if.sv =====
// Result channel of the block cache slot manager.
// Depends on bcsm_pkg for field widths.
interface bcsm_out_if;
  import bcsm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] slot_used;
  logic                hit;
  logic [DOP_W-1:0]    disk_op;
  logic [BLOCK_W-1:0]  disk_block;
  logic                last;

  modport source (output valid, output status, output slot_used, output hit,
                  output disk_op, output disk_block, output last, input ready);
  modport sink   (input valid, input status, input slot_used, input hit,
                  input disk_op, input disk_block, input last, output ready);
endinterface

// ===== rtl/bcsm_cell.sv =====
// One cache slot: valid, dirty, count and tag, plus its stage of the scan chain.
// Depends on bcsm_pkg.
module bcsm_cell
  import bcsm_pkg::*;
#(
  parameter int unsigned SlotW      = 5,
  parameter int unsigned CountBits  = DefCountBits,
  parameter int unsigned CellIdx    = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [BLOCK_W-1:0] key_i,
  input  cell_cmd_t          cmd_i,
  input  logic [SlotW-1:0]   target_i,
  input  link_t              link_i,
  output link_t              link_o,
  output cell_flags_t        flags_o
);

  logic                 valid_q, valid_d;
  logic                 dirty_q, dirty_d;
  logic [BLOCK_W-1:0]   tag_q, tag_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic                 sel, cnt_max, cnt_zero, match, cand, hit_here, free_here, dirty_here;

  assign sel      = (target_i == SlotW'(CellIdx)) && (cmd_i.op != CO_NONE);
  assign cnt_max  = (cnt_q == {CountBits{1'b1}});
  assign cnt_zero = (cnt_q == '0);
  assign match    = valid_q && (tag_q == key_i);
  assign cand     = valid_q && dirty_q;

  assign hit_here   = match && !link_i.hit_found;
  assign free_here  = cnt_zero && !link_i.free_found;
  assign dirty_here = cand && !link_i.dirty_found;

  always_comb begin
    link_o.hit_found   = link_i.hit_found | match;
    link_o.hit_max     = hit_here ? cnt_max : link_i.hit_max;
    link_o.free_found  = link_i.free_found | cnt_zero;
    link_o.free_wb     = free_here ? cand : link_i.free_wb;
    link_o.free_tag    = free_here ? tag_q : link_i.free_tag;
    link_o.dirty_found = link_i.dirty_found | cand;
    link_o.dirty_more  = link_i.dirty_more | (cand && link_i.dirty_found);
    link_o.dirty_tag   = dirty_here ? tag_q : link_i.dirty_tag;
  end

  assign flags_o.valid       = valid_q;
  assign flags_o.cnt_zero    = cnt_zero;
  assign flags_o.hit_first   = hit_here;
  assign flags_o.free_first  = free_here;
  assign flags_o.dirty_first = dirty_here;

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    tag_d   = tag_q;
    cnt_d   = cnt_q;
    if (sel) begin
      case (cmd_i.op)
        CO_INC: begin
          if (!cnt_max) cnt_d = cnt_q + CountBits'(1);
        end
        CO_DEC: begin
          if (!cnt_zero) cnt_d = cnt_q - CountBits'(1);
        end
        CO_DIRTY: dirty_d = 1'b1;
        CO_CLEAN: dirty_d = 1'b0;
        CO_FILL: begin
          valid_d = 1'b1;
          dirty_d = 1'b0;
          tag_d   = cmd_i.tag;
          cnt_d   = CountBits'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      tag_q   <= '0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      tag_q   <= tag_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/block_cache_slot_manager.sv =====
// Block cache slot manager: a row of slot cells, one per cache slot, scanned
// through a ripple chain, behind a controller with one result register.
// Depends on bcsm_pkg, bcsm_in_if, bcsm_out_if and bcsm_cell.
//
// One command is handled at a time. A command is registered when it is taken, and
// each result is then loaded into the single result register, with all slot
// tags compared at once. Acquire hit, miss without write-back, mark-dirty and
// release give one result; a miss that writes back a dirty slot gives a
// write-back result, then a fill result from the fetch state; sync writes back
// each dirty slot in turn, one write-back per cycle while the result register is
// not stalled, or gives one result with no transfer if none is dirty. The lowest
// free slot and lowest dirty slot come from the cell chain, so its length of
// SLOT_COUNT cells sets the critical path. No clearing pass is needed after reset.
module block_cache_slot_manager
  import bcsm_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = DefSlotCount,
  parameter int unsigned COUNT_BITS = DefCountBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcsm_in_if.sink    in_i,
  bcsm_out_if.source out_o
);

  localparam int unsigned SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  state_e                state_q, state_d;
  cmd_e                  cmd_q;
  logic [BLOCK_W-1:0]    blk_q;
  logic [HANDLE_W-1:0]   idx_q;

  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [HANDLE_W-1:0]   slot_q, slot_d;
  logic                  hit_q, hit_d;
  logic [DOP_W-1:0]      dop_q, dop_d;
  logic [BLOCK_W-1:0]    dblk_q, dblk_d;
  logic                  last_q, last_d;

  link_t                 link [SLOT_COUNT+1];
  cell_flags_t           flags [SLOT_COUNT];
  cell_cmd_t             cell_cmd;
  logic [SlotW-1:0]      target;

  logic [SLOT_COUNT-1:0] valid_vec, zero_vec;
  logic [SlotW-1:0]      hit_idx, free_idx, dirty_idx, slot_sel;
  logic                  slot_ok, out_free, load;
  link_t                 scan;

  assign link[0] = '0;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    bcsm_cell #(
      .SlotW    (SlotW),
      .CountBits(COUNT_BITS),
      .CellIdx  (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (blk_q),
      .cmd_i   (cell_cmd),
      .target_i(target),
      .link_i  (link[g]),
      .link_o  (link[g+1]),
      .flags_o (flags[g])
    );
    assign valid_vec[g] = flags[g].valid;
    assign zero_vec[g]  = flags[g].cnt_zero;
  end

  assign scan = link[SLOT_COUNT];

  always_comb begin
    hit_idx   = '0;
    free_idx  = '0;
    dirty_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (flags[i].hit_first)   hit_idx   = hit_idx   | SlotW'(i);
      if (flags[i].free_first)  free_idx  = free_idx  | SlotW'(i);
      if (flags[i].dirty_first) dirty_idx = dirty_idx | SlotW'(i);
    end
  end

  assign slot_ok  = (32'(idx_q) < 32'(SLOT_COUNT));
  assign slot_sel = SlotW'(idx_q);
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    load         = 1'b0;
    status_d     = STS_OK;
    slot_d       = '0;
    hit_d        = 1'b0;
    dop_d        = DOP_NONE;
    dblk_d       = '0;
    last_d       = 1'b1;
    cell_cmd.op  = CO_NONE;
    cell_cmd.tag = blk_q;
    target       = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
          case (cmd_q)
            CMD_ACQUIRE: begin
              if (scan.hit_found) begin
                hit_d    = 1'b1;
                slot_d   = HANDLE_W'(hit_idx);
                status_d = scan.hit_max ? STS_SATURATED : STS_OK;
                if (!scan.hit_max) begin
                  cell_cmd.op = CO_INC;
                  target      = hit_idx;
                end
              end else if (!scan.free_found) begin
                status_d = STS_NO_FREE;
              end else if (scan.free_wb) begin
                slot_d  = HANDLE_W'(free_idx);
                dop_d   = DOP_WRITE;
                dblk_d  = scan.free_tag;
                last_d  = 1'b0;
                state_d = ST_FETCH;
              end else begin
                slot_d      = HANDLE_W'(free_idx);
                dop_d       = DOP_READ;
                dblk_d      = blk_q;
                cell_cmd.op = CO_FILL;
                target      = free_idx;
              end
            end
            CMD_MARK: begin
              slot_d = idx_q;
              if (!slot_ok || !valid_vec[slot_sel]) begin
                status_d = STS_IGNORED;
              end else begin
                cell_cmd.op = CO_DIRTY;
                target      = slot_sel;
              end
            end
            CMD_RELEASE: begin
              slot_d = idx_q;
              if (!slot_ok) begin
                status_d = STS_IGNORED;
              end else if (zero_vec[slot_sel]) begin
                status_d = STS_UNDERFLOW;
              end else begin
                cell_cmd.op = CO_DEC;
                target      = slot_sel;
              end
            end
            CMD_SYNC: begin
              if (scan.dirty_found) begin
                slot_d      = HANDLE_W'(dirty_idx);
                dop_d       = DOP_WRITE;
                dblk_d      = scan.dirty_tag;
                last_d      = !scan.dirty_more;
                cell_cmd.op = CO_CLEAN;
                target      = dirty_idx;
                if (scan.dirty_more) state_d = ST_EXEC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        if (out_free) begin
          load        = 1'b1;
          state_d     = ST_IDLE;
          slot_d      = HANDLE_W'(free_idx);
          dop_d       = DOP_READ;
          dblk_d      = blk_q;
          cell_cmd.op = CO_FILL;
          target      = free_idx;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q <= cmd_e'(in_i.command);
      blk_q <= in_i.block_number;
      idx_q <= in_i.slot_index;
    end
    if (load) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      hit_q    <= hit_d;
      dop_q    <= dop_d;
      dblk_q   <= dblk_d;
      last_q   <= last_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.slot_used  = slot_q;
  assign out_o.hit        = hit_q;
  assign out_o.disk_op    = dop_q;
  assign out_o.disk_block = dblk_q;
  assign out_o.last       = last_q;

endmodule

// ===== rtl/bcsm_checker.sv =====
// Port-level checks of the block cache slot manager, bound to the top level.
// Depends on bcsm_pkg and block_cache_slot_manager.
module bcsm_checker
  import bcsm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_i,
  input logic                hit_i,
  input logic [DOP_W-1:0]    disk_op_i,
  input logic [BLOCK_W-1:0]  disk_block_i,
  input logic                last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(disk_block_i) && $stable(last_i))
    else $error("result changed while stalled");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second command taken while busy");

  a_no_op_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (disk_op_i == DOP_NONE) |-> (disk_block_i == '0))
    else $error("disk block set without disk transfer");

  a_hit_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hit_i |-> (disk_op_i == DOP_NONE) && last_i &&
      ((status_i == STS_OK) || (status_i == STS_SATURATED)))
    else $error("malformed hit result");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != STS_OK) |-> last_i)
    else $error("error result not final");

endmodule

bind block_cache_slot_manager bcsm_checker u_bcsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .hit_i       (out_o.hit),
  .disk_op_i   (out_o.disk_op),
  .disk_block_i(out_o.disk_block),
  .last_i      (out_o.last)
);

// ===== verif/testbench.sv =====
// Testbench of block_cache_slot_manager: directed table, then random traffic on both channels.
// Results are checked field by field against a predictor of the slot tags and counts.
// Depends on bcsm_pkg, bcsm_in_if, bcsm_out_if and the RTL top level.
module testbench;
  import bcsm_pkg::*;

  localparam int SLOTS    = DefSlotCount;
  localparam int REFS_MAX = (1 << DefCountBits) - 1;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] slot;
    logic                hit;
    disk_op_e            disk_op;
    logic [BLOCK_W-1:0]  disk_block;
    logic                last;
  } slot_result_t;

  typedef struct packed {
    cmd_e                cmd;
    logic [BLOCK_W-1:0]  blk;
    logic [HANDLE_W-1:0] idx;
    logic                typed;
    slot_result_t        res;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;

  bcsm_in_if  in_if ();
  bcsm_out_if out_if ();

  block_cache_slot_manager #(
    .SLOT_COUNT (DefSlotCount),
    .COUNT_BITS (DefCountBits)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bit                  slot_valid [SLOTS];
  bit                  slot_dirty [SLOTS];
  logic [BLOCK_W-1:0]  slot_tag   [SLOTS] = '{default: '0};
  int                  slot_refs  [SLOTS];

  slot_result_t        pending_results [$];
  logic [BLOCK_W-1:0]  block_pool [40];
  bit                  typed_pending;
  slot_result_t        typed_result;
  bit                  calm;
  int                  result_stall;
  int                  mismatches;
  int                  results_checked;
  int                  commands_taken;
  int                  hits;
  int                  saturations;
  int                  full_misses;
  int                  writebacks;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results pending", pending_results.size());
    $display("testbench NOT OK");
    $finish;
  end

  function automatic int draw_wait();
    return calm ? 0 : int'($urandom_range(8, 0));
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("result %0d: %s", results_checked, what);
  endtask

  task automatic push_result(input status_e st, input int slot, input logic hit,
                             input disk_op_e op, input logic [BLOCK_W-1:0] blk,
                             input logic last);
    slot_result_t r;
    r.status     = st;
    r.slot       = HANDLE_W'(slot);
    r.hit        = hit;
    r.disk_op    = op;
    r.disk_block = blk;
    r.last       = last;
    pending_results.push_back(r);
  endtask

  task automatic predict_command(input cmd_e cmd, input logic [BLOCK_W-1:0] blk,
                                 input logic [HANDLE_W-1:0] idx);
    int found;
    int wrote;
    slot_result_t tail;
    found = -1;
    wrote = 0;
    case (cmd)
      CMD_ACQUIRE: begin
        for (int s = 0; s < SLOTS; s++)
          if (found < 0 && slot_valid[s] && slot_tag[s] == blk) found = s;
        if (found >= 0) begin
          hits++;
          if (slot_refs[found] >= REFS_MAX) begin
            saturations++;
            push_result(STS_SATURATED, found, 1'b1, DOP_NONE, '0, 1'b1);
          end else begin
            slot_refs[found]++;
            push_result(STS_OK, found, 1'b1, DOP_NONE, '0, 1'b1);
          end
        end else begin
          for (int s = 0; s < SLOTS; s++)
            if (found < 0 && slot_refs[s] == 0) found = s;
          if (found < 0) begin
            full_misses++;
            push_result(STS_NO_FREE, 0, 1'b0, DOP_NONE, '0, 1'b1);
          end else begin
            if (slot_valid[found] && slot_dirty[found]) begin
              writebacks++;
              push_result(STS_OK, found, 1'b0, DOP_WRITE, slot_tag[found], 1'b0);
            end
            push_result(STS_OK, found, 1'b0, DOP_READ, blk, 1'b1);
            slot_tag[found]   = blk;
            slot_valid[found] = 1'b1;
            slot_dirty[found] = 1'b0;
            slot_refs[found]  = 1;
          end
        end
      end
      CMD_MARK: begin
        if (int'(idx) >= SLOTS || !slot_valid[idx]) begin
          push_result(STS_IGNORED, int'(idx), 1'b0, DOP_NONE, '0, 1'b1);
        end else begin
          slot_dirty[idx] = 1'b1;
          push_result(STS_OK, int'(idx), 1'b0, DOP_NONE, '0, 1'b1);
        end
      end
      CMD_RELEASE: begin
        if (int'(idx) >= SLOTS) begin
          push_result(STS_IGNORED, int'(idx), 1'b0, DOP_NONE, '0, 1'b1);
        end else if (slot_refs[idx] == 0) begin
          push_result(STS_UNDERFLOW, int'(idx), 1'b0, DOP_NONE, '0, 1'b1);
        end else begin
          slot_refs[idx]--;
          push_result(STS_OK, int'(idx), 1'b0, DOP_NONE, '0, 1'b1);
        end
      end
      default: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_valid[s] && slot_dirty[s]) begin
            writebacks++;
            wrote++;
            push_result(STS_OK, s, 1'b0, DOP_WRITE, slot_tag[s], 1'b0);
            slot_dirty[s] = 1'b0;
          end
        end
        if (wrote == 0) begin
          push_result(STS_OK, 0, 1'b0, DOP_NONE, '0, 1'b1);
        end else begin
          tail = pending_results.pop_back();
          tail.last = 1'b1;
          pending_results.push_back(tail);
        end
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    slot_result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        result_stall = draw_wait();
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("transfer with no result pending, disk_op %0d block %h",
                                    out_if.disk_op, out_if.disk_block));
        end else begin
          want = pending_results.pop_front();
          if (out_if.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_if.status, want.status));
          if (out_if.slot_used !== want.slot)
            report_mismatch($sformatf("slot_used %0d, want %0d", out_if.slot_used, want.slot));
          if (out_if.hit !== want.hit)
            report_mismatch($sformatf("hit %0b, want %0b", out_if.hit, want.hit));
          if (out_if.disk_op !== want.disk_op)
            report_mismatch($sformatf("disk_op %0d, want %0d", out_if.disk_op, want.disk_op));
          if (out_if.disk_block !== want.disk_block)
            report_mismatch($sformatf("disk_block %h, want %h", out_if.disk_block,
                                      want.disk_block));
          if (out_if.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", out_if.last, want.last));
        end
        results_checked++;
      end
      if (in_if.valid && in_if.ready) begin
        commands_taken++;
        predict_command(cmd_e'(in_if.command), in_if.block_number, in_if.slot_index);
        if (typed_pending) begin
          void'(pending_results.pop_back());
          pending_results.push_back(typed_result);
        end
      end
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (result_stall > 0) begin
        out_if.ready = 1'b0;
        result_stall--;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  task automatic send_item(input cmd_e cmd, input logic [BLOCK_W-1:0] blk,
                           input logic [HANDLE_W-1:0] idx);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid        = 1'b1;
    in_if.command      = cmd;
    in_if.block_number = blk;
    in_if.slot_index   = idx;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [HANDLE_W-1:0] pick_slot(input bit by_refs);
    int start;
    int s;
    start = int'($urandom_range(SLOTS - 1, 0));
    for (int k = 0; k < SLOTS; k++) begin
      s = (start + k) % SLOTS;
      if (by_refs ? slot_refs[s] != 0 : slot_valid[s]) return HANDLE_W'(s);
    end
    return HANDLE_W'($urandom);
  endfunction

  function automatic logic [BLOCK_W-1:0] pick_block();
    if ($urandom_range(99, 0) < 85) return block_pool[$urandom_range(39, 0)];
    return $urandom;
  endfunction

  task automatic run_mix(input int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = int'($urandom_range(99, 0));
      if (r < 40)
        send_item(CMD_ACQUIRE, pick_block(), HANDLE_W'($urandom));
      else if (r < 60)
        send_item(CMD_MARK, $urandom,
                  ($urandom_range(4, 0) != 0) ? pick_slot(1'b0) : HANDLE_W'($urandom));
      else if (r < 90)
        send_item(CMD_RELEASE, $urandom,
                  ($urandom_range(4, 0) != 0) ? pick_slot(1'b1) : HANDLE_W'($urandom));
      else
        send_item(CMD_SYNC, $urandom, HANDLE_W'($urandom));
    end
  endtask

  function automatic directed_row_t plan_row(input cmd_e c, input logic [BLOCK_W-1:0] b,
                                             input logic [HANDLE_W-1:0] i, input bit t = 1'b0,
                                             input status_e st = STS_OK,
                                             input logic [HANDLE_W-1:0] sl = '0,
                                             input bit h = 1'b0,
                                             input disk_op_e op = DOP_NONE,
                                             input logic [BLOCK_W-1:0] db = '0);
    directed_row_t row;
    row.cmd            = c;
    row.blk            = b;
    row.idx            = i;
    row.typed          = t;
    row.res.status     = st;
    row.res.slot       = sl;
    row.res.hit        = h;
    row.res.disk_op    = op;
    row.res.disk_block = db;
    row.res.last       = 1'b1;
    return row;
  endfunction

  initial begin : stimulus
    directed_row_t plan [$];
    int n;
    int s;
    in_if.valid        = 1'b0;
    in_if.command      = CMD_ACQUIRE;
    in_if.block_number = '0;
    in_if.slot_index   = '0;
    rst_ni             = 1'b0;
    for (int k = 0; k < 40; k++) block_pool[k] = $urandom;
    block_pool[0] = '0;
    block_pool[1] = '1;

    plan.push_back(plan_row(CMD_SYNC, '1, 5'd31, 1'b1, STS_OK, 5'd0));
    plan.push_back(plan_row(CMD_MARK, '0, 5'd0, 1'b1, STS_IGNORED, 5'd0));
    plan.push_back(plan_row(CMD_RELEASE, '0, 5'd31, 1'b1, STS_UNDERFLOW, 5'd31));
    plan.push_back(plan_row(CMD_ACQUIRE, '0, 5'd31, 1'b1, STS_OK, 5'd0, 1'b0, DOP_READ, '0));
    plan.push_back(plan_row(CMD_ACQUIRE, '1, 5'd0, 1'b1, STS_OK, 5'd1, 1'b0, DOP_READ, '1));
    plan.push_back(plan_row(CMD_ACQUIRE, '0, 5'd0, 1'b1, STS_OK, 5'd0, 1'b1));
    plan.push_back(plan_row(CMD_MARK, '1, 5'd1, 1'b1, STS_OK, 5'd1));
    plan.push_back(plan_row(CMD_MARK, '0, 5'd31, 1'b1, STS_IGNORED, 5'd31));
    plan.push_back(plan_row(CMD_RELEASE, '0, 5'd1, 1'b1, STS_OK, 5'd1));
    plan.push_back(plan_row(CMD_ACQUIRE, 32'h1234_5678, 5'd0));
    plan.push_back(plan_row(CMD_MARK, '1, 5'd1));
    plan.push_back(plan_row(CMD_MARK, '0, 5'd0));
    plan.push_back(plan_row(CMD_SYNC, '0, 5'd0));
    plan.push_back(plan_row(CMD_SYNC, '0, 5'd0, 1'b1, STS_OK, 5'd0));
    plan.push_back(plan_row(CMD_RELEASE, '0, 5'd0));
    plan.push_back(plan_row(CMD_RELEASE, '1, 5'd0));
    plan.push_back(plan_row(CMD_RELEASE, '0, 5'd0, 1'b1, STS_UNDERFLOW, 5'd0));
    plan.push_back(plan_row(CMD_ACQUIRE, 32'hAAAA_AAAA, 5'd0));
    plan.push_back(plan_row(CMD_ACQUIRE, 32'h5555_5555, 5'd0));
    plan.push_back(plan_row(CMD_MARK, '0, 5'd2));
    plan.push_back(plan_row(CMD_RELEASE, '0, 5'd2));
    plan.push_back(plan_row(CMD_ACQUIRE, 32'h8000_0000, 5'd0));
    plan.push_back(plan_row(CMD_ACQUIRE, 32'h8000_0000, 5'd0));
    plan.push_back(plan_row(CMD_SYNC, '0, 5'd0));

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[k]) begin
      typed_pending = plan[k].typed;
      typed_result  = plan[k].res;
      send_item(plan[k].cmd, plan[k].blk, plan[k].idx);
    end
    typed_pending = 1'b0;
    wait_drained();

    run_mix(70);

    // fill every free slot with fresh blocks until the cache runs full
    for (int k = 0; k < 40; k++) send_item(CMD_ACQUIRE, $urandom, HANDLE_W'($urandom));
    wait_drained();

    calm = 1'b1;
    for (int k = 0; k < 40; k++) begin
      if (k % 2 == 0) send_item(CMD_RELEASE, $urandom, pick_slot(1'b1));
      else send_item(CMD_MARK, $urandom, pick_slot(1'b0));
    end
    send_item(CMD_SYNC, $urandom, HANDLE_W'($urandom));
    calm = 1'b0;

    run_mix(60);
    wait_drained();

    // drive the busiest slot's count into saturation
    s = 0;
    for (int k = 0; k < SLOTS; k++)
      if (slot_valid[k] && (!slot_valid[s] || slot_refs[k] > slot_refs[s])) s = k;
    n = REFS_MAX - slot_refs[s] + 3;
    for (int k = 0; k < n; k++) begin
      calm = (k >= n / 2);
      if (k % 32 == 31) send_item(CMD_SYNC, $urandom, HANDLE_W'($urandom));
      send_item(CMD_ACQUIRE, slot_tag[s], HANDLE_W'($urandom));
    end
    calm = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("covered %0d commands, %0d results checked, %0d mismatches", commands_taken,
             results_checked, mismatches);
    $display("seen %0d hits, %0d saturated, %0d full-cache misses, %0d write-backs", hits,
             saturations, full_misses, writebacks);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bcsm_pkg.sv
rtl/bcsm_in_if.sv
rtl/bcsm_out_if.sv
rtl/bcsm_cell.sv
rtl/block_cache_slot_manager.sv
rtl/bcsm_checker.sv
verif/testbench.sv
